@@ rtl/csf_pkg.sv @@
// Shared types, constants and helpers for the counting semaphore with a waiter queue.
// Used by the front, back and top-level modules and by the testbench; depends on nothing else.
package csf_pkg;

   localparam int QUEUE_DEPTH = 16;
   localparam int TID_W       = 8;
   localparam int VALUE_W     = 16;
   localparam int PTR_W       = $clog2(QUEUE_DEPTH);
   localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);

   localparam logic signed [VALUE_W-1:0] COUNT_MAX = {1'b0, {(VALUE_W-1){1'b1}}};
   localparam logic signed [VALUE_W-1:0] COUNT_MIN = {1'b1, {(VALUE_W-1){1'b0}}};

   // Operation codes carried by the kind field.
   typedef enum logic [1:0] {
      OP_OPEN   = 2'd0,
      OP_WAIT   = 2'd1,
      OP_SIGNAL = 2'd2,
      OP_CLOSE  = 2'd3
   } csf_op_type;

   // Status codes of a result word.
   typedef enum logic [1:0] {
      ST_OK     = 2'd0,
      ST_CLOSED = 2'd1,
      ST_FULL   = 2'd2
   } csf_status_type;

   // Classified command passed from the front to the back.
   typedef struct packed {
      csf_op_type                 op;
      logic [TID_W-1:0]           tid;
      logic signed [VALUE_W-1:0]  open_value;
   } csf_cmd_type;

   // One result word.
   typedef struct packed {
      csf_status_type   status;
      logic             must_block;
      logic             rel_valid;
      logic [TID_W-1:0] rel_thread;
      logic             last;
   } csf_rsp_type;

   // Status of the back end seen by the top level.
   typedef struct packed {
      logic [CNT_W-1:0] waiter_count;
      logic             busy;
   } csf_stat_type;

   // Next slot of the circular waiter queue.
   function automatic logic [PTR_W-1:0] next_slot(input logic [PTR_W-1:0] p);
      logic [PTR_W-1:0] r;
      if (p == PTR_W'(QUEUE_DEPTH - 1)) begin
         r = '0;
      end else begin
         r = p + 1'b1;
      end
      return r;
   endfunction

endpackage

@@ rtl/csf_ram.sv @@
// Generic single-write, single-read RAM with a registered read port.
// Stand-alone; holds the waiter thread ids.
module csf_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic                     re,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   // Write port and registered read port; read data holds while re is low.
   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem_ff[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

@@ rtl/csf_front.sv @@
// Front end: accepts request words, classifies them into commands and queues them.
// Depends on csf_pkg.
module csf_front
   import csf_pkg::*;
(
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_push,
   output logic                       req_full,
   input  logic [1:0]                 req_kind,
   input  logic [TID_W-1:0]           req_thread_id,
   input  logic signed [VALUE_W-1:0]  req_open_value,
   output logic                       cmd_valid,
   output csf_cmd_type                cmd,
   input  logic                       cmd_take
);

   csf_cmd_type slot_ff [2];
   logic        head_ff, head_in;
   logic [1:0]  cnt_ff, cnt_in;
   logic        push_ok, pop_ok, tail;
   csf_cmd_type cmd_new;

   // Classify the incoming word.
   always_comb begin
      cmd_new.op         = csf_op_type'(req_kind);
      cmd_new.tid        = req_thread_id;
      cmd_new.open_value = req_open_value;
   end

   // Two-entry command queue between the front and the back.
   assign req_full  = (cnt_ff == 2'd2);
   assign push_ok   = req_push && !req_full;
   assign cmd_valid = (cnt_ff != 2'd0);
   assign pop_ok    = cmd_take && cmd_valid;
   assign tail      = head_ff ^ cnt_ff[0];
   assign cmd       = slot_ff[head_ff];

   always_comb begin
      head_in = head_ff ^ pop_ok;
      cnt_in  = cnt_ff + {1'b0, push_ok} - {1'b0, pop_ok};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff <= 1'b0;
         cnt_ff  <= 2'd0;
      end else begin
         head_ff <= head_in;
         cnt_ff  <= cnt_in;
      end
      if (push_ok) begin
         slot_ff[tail] <= cmd_new;
      end
   end

endmodule

@@ rtl/csf_back.sv @@
// Back end: carries out commands on the count and the waiter queue, and queues results.
// Depends on csf_pkg and csf_ram.
module csf_back
   import csf_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             cmd_valid,
   input  csf_cmd_type      cmd,
   output logic             cmd_take,
   output logic             rsp_empty,
   input  logic             rsp_pop,
   output csf_rsp_type      rsp,
   output csf_stat_type     stat
);

   typedef enum logic {
      S_IDLE,
      S_FETCH
   } state_type;

   state_type                  state_ff, state_in;
   logic signed [VALUE_W-1:0]  count_ff, count_in;
   logic                       closed_ff, closed_in;
   logic [PTR_W-1:0]           rp_ff, rp_in, wp_ff, wp_in;
   logic [CNT_W-1:0]           wc_ff, wc_in;
   csf_op_type                 op_ff, op_in;
   csf_status_type             sig_status_ff, sig_status_in;
   csf_status_type             sig_status;

   csf_rsp_type                rq_ff [2];
   logic                       rq_head_ff, rq_head_in;
   logic [1:0]                 rq_cnt_ff, rq_cnt_in;
   logic                       room, push, pop_ok, rq_tail;
   csf_rsp_type                res;

   logic                       ram_we, ram_re;
   logic [PTR_W-1:0]           ram_raddr;
   logic [TID_W-1:0]           ram_rdata;

   // Waiter queue storage.
   csf_ram #(
      .WIDTH(TID_W),
      .DEPTH(QUEUE_DEPTH)
   ) u_waiters (
      .clock (clock),
      .we    (ram_we),
      .waddr (wp_ff),
      .wdata (cmd.tid),
      .re    (ram_re),
      .raddr (ram_raddr),
      .rdata (ram_rdata)
   );

   assign room       = (rq_cnt_ff != 2'd2);
   assign rsp_empty  = (rq_cnt_ff == 2'd0);
   assign pop_ok     = rsp_pop && !rsp_empty;
   assign rq_tail    = rq_head_ff ^ rq_cnt_ff[0];
   assign rsp        = rq_ff[rq_head_ff];
   assign stat.waiter_count = wc_ff;
   assign stat.busy         = (state_ff == S_FETCH);
   assign sig_status = (count_ff == COUNT_MAX) ? ST_FULL : ST_OK;

   // Command execution.
   always_comb begin
      state_in      = state_ff;
      count_in      = count_ff;
      closed_in     = closed_ff;
      rp_in         = rp_ff;
      wp_in         = wp_ff;
      wc_in         = wc_ff;
      op_in         = op_ff;
      sig_status_in = sig_status_ff;
      cmd_take      = 1'b0;
      push          = 1'b0;
      res           = '0;
      ram_we        = 1'b0;
      ram_re        = 1'b0;
      ram_raddr     = rp_ff;

      unique case (state_ff)
         S_IDLE: begin
            if (cmd_valid && room) begin
               cmd_take = 1'b1;
               op_in    = cmd.op;
               unique case (cmd.op)
                  OP_OPEN: begin
                     count_in  = cmd.open_value;
                     closed_in = 1'b0;
                     rp_in     = '0;
                     wp_in     = '0;
                     wc_in     = '0;
                     push      = 1'b1;
                     res.last  = 1'b1;
                  end
                  OP_WAIT: begin
                     push     = 1'b1;
                     res.last = 1'b1;
                     priority if (closed_ff) begin
                        res.status = ST_CLOSED;
                     end else if (count_ff == COUNT_MIN) begin
                        res.status = ST_FULL;
                     end else if (count_ff <= $signed(VALUE_W'(0))) begin
                        if (wc_ff == CNT_W'(QUEUE_DEPTH)) begin
                           res.status = ST_FULL;
                        end else begin
                           ram_we         = 1'b1;
                           wp_in          = next_slot(wp_ff);
                           wc_in          = wc_ff + 1'b1;
                           count_in       = count_ff - VALUE_W'(1);
                           res.must_block = 1'b1;
                        end
                     end else begin
                        count_in = count_ff - VALUE_W'(1);
                     end
                  end
                  OP_SIGNAL: begin
                     if (sig_status == ST_OK) begin
                        count_in = count_ff + VALUE_W'(1);
                     end
                     if (wc_ff == '0) begin
                        push       = 1'b1;
                        res.status = sig_status;
                        res.last   = 1'b1;
                     end else begin
                        ram_re        = 1'b1;
                        sig_status_in = sig_status;
                        state_in      = S_FETCH;
                     end
                  end
                  OP_CLOSE: begin
                     closed_in = 1'b1;
                     if (wc_ff == '0) begin
                        push     = 1'b1;
                        res.last = 1'b1;
                     end else begin
                        ram_re   = 1'b1;
                        state_in = S_FETCH;
                     end
                  end
                  default: ;
               endcase
            end
         end
         S_FETCH: begin
            // One released waiter per result word; close keeps reading ahead.
            if (room) begin
               push           = 1'b1;
               res.status     = (op_ff == OP_SIGNAL) ? sig_status_ff : ST_OK;
               res.rel_valid  = 1'b1;
               res.rel_thread = ram_rdata;
               res.last       = (op_ff == OP_SIGNAL) || (wc_ff == CNT_W'(1));
               rp_in          = next_slot(rp_ff);
               wc_in          = wc_ff - 1'b1;
               if (res.last) begin
                  state_in = S_IDLE;
                  if (op_ff == OP_CLOSE) begin
                     rp_in = '0;
                     wp_in = '0;
                     wc_in = '0;
                  end
               end else begin
                  ram_re    = 1'b1;
                  ram_raddr = next_slot(rp_ff);
               end
            end
         end
         default: ;
      endcase
   end

   // Result queue bookkeeping.
   always_comb begin
      rq_head_in = rq_head_ff ^ pop_ok;
      rq_cnt_in  = rq_cnt_ff + {1'b0, push} - {1'b0, pop_ok};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= S_IDLE;
         count_ff   <= '0;
         closed_ff  <= 1'b0;
         rp_ff      <= '0;
         wp_ff      <= '0;
         wc_ff      <= '0;
         rq_head_ff <= 1'b0;
         rq_cnt_ff  <= 2'd0;
      end else begin
         state_ff   <= state_in;
         count_ff   <= count_in;
         closed_ff  <= closed_in;
         rp_ff      <= rp_in;
         wp_ff      <= wp_in;
         wc_ff      <= wc_in;
         rq_head_ff <= rq_head_in;
         rq_cnt_ff  <= rq_cnt_in;
      end
      op_ff         <= op_in;
      sig_status_ff <= sig_status_in;
      if (push) begin
         rq_ff[rq_tail] <= res;
      end
   end

endmodule

@@ rtl/counting_semaphore_fifo_waiters.sv @@
// Open, wait and signal without a waiter are carried out in the idle state of the back
// end; a signal that releases a waiter, and a close with queued waiters, go through a
// fetch state, as the waiter RAM has a registered read port; close gives one result word
// per queued waiter. Front and back each hold a two-word queue.
// Synchronous reset clears the count, the closed flag, pointers and both word queues.
module counting_semaphore_fifo_waiters
   import csf_pkg::*;
(
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_push,
   output logic                       req_full,
   input  logic [1:0]                 req_kind,
   input  logic [TID_W-1:0]           req_thread_id,
   input  logic signed [VALUE_W-1:0]  req_open_value,
   output logic                       rsp_empty,
   input  logic                       rsp_pop,
   output logic [1:0]                 rsp_status,
   output logic                       rsp_must_block,
   output logic                       rsp_released_valid,
   output logic [TID_W-1:0]           rsp_released_thread,
   output logic                       rsp_last
);

   logic         cmd_valid, cmd_take;
   csf_cmd_type  cmd;
   csf_rsp_type  rsp;
   csf_stat_type stat;

   // Front end: accept and classify.
   csf_front u_front (
      .clock          (clock),
      .reset          (reset),
      .req_push       (req_push),
      .req_full       (req_full),
      .req_kind       (req_kind),
      .req_thread_id  (req_thread_id),
      .req_open_value (req_open_value),
      .cmd_valid      (cmd_valid),
      .cmd            (cmd),
      .cmd_take       (cmd_take)
   );

   // Back end: execute and queue results.
   csf_back u_back (
      .clock     (clock),
      .reset     (reset),
      .cmd_valid (cmd_valid),
      .cmd       (cmd),
      .cmd_take  (cmd_take),
      .rsp_empty (rsp_empty),
      .rsp_pop   (rsp_pop),
      .rsp       (rsp),
      .stat      (stat)
   );

   assign rsp_status          = rsp.status;
   assign rsp_must_block      = rsp.must_block;
   assign rsp_released_valid  = rsp.rel_valid;
   assign rsp_released_thread = rsp.rel_thread;
   assign rsp_last            = rsp.last;

   // The waiter count never exceeds the queue depth.
   a_wc_bound: assert property (@(posedge clock) disable iff (reset)
      stat.waiter_count <= CNT_W'(QUEUE_DEPTH))
      else $error("waiter count above queue depth");

   // The back end takes a command only when one is queued.
   a_take_valid: assert property (@(posedge clock) disable iff (reset)
      cmd_take |-> cmd_valid)
      else $error("command taken from an empty queue");

   // A blocked caller is never also a release, and ends its item.
   a_block_word: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && rsp_must_block) |-> (rsp_last && !rsp_released_valid))
      else $error("malformed blocking result word");

   // Nothing is fetched from an empty waiter queue.
   a_fetch_nonempty: assert property (@(posedge clock) disable iff (reset)
      stat.busy |-> (stat.waiter_count != '0))
      else $error("release pending with no waiters");

endmodule

@@ tb/sv/tb_top.sv @@
// Self-checking testbench for counting_semaphore_fifo_waiters: open, wait, signal and close.
// A scoreboard class predicts every result word; a task drives the request queue and an always block the result queue.
// Depends on csf_pkg and the counting_semaphore_fifo_waiters RTL.
module tb_top;
   import csf_pkg::*;

   // Receiver pop patterns.
   localparam int POP_ALWAYS = 0;
   localparam int POP_RANDOM = 1;
   localparam int POP_BURSTY = 2;

   // Random stimulus scenarios.
   localparam int SC_MIXED = 0;
   localparam int SC_FILL  = 1;
   localparam int SC_EDGE  = 2;
   localparam int SC_NOISE = 3;

   localparam int RANDOM_WORDS = 220;

   // Predicts the semaphore and holds the result words still to come.
   class semaphore_score;
      csf_rsp_type               expected_words[$];
      logic signed [VALUE_W-1:0] count;
      logic                      closed;
      logic [TID_W-1:0]          waiters[QUEUE_DEPTH];
      logic [PTR_W-1:0]          rd_ptr;
      logic [PTR_W-1:0]          wr_ptr;
      int                        queued;
      int                        failures;

      function new();
         count    = '0;
         closed   = 1'b0;
         rd_ptr   = '0;
         wr_ptr   = '0;
         queued   = 0;
         failures = 0;
      endfunction

      function void queue_result(csf_status_type st, logic blk, logic rv,
                                 logic [TID_W-1:0] rt, logic lst);
         csf_rsp_type w;
         w.status     = st;
         w.must_block = blk;
         w.rel_valid  = rv;
         w.rel_thread = rt;
         w.last       = lst;
         expected_words.push_back(w);
      endfunction

      // Removes the oldest waiter from the circular queue.
      function logic [TID_W-1:0] take_waiter();
         logic [TID_W-1:0] t;
         t      = waiters[rd_ptr];
         rd_ptr = (rd_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
         queued--;
         return t;
      endfunction

      // Applies one accepted request word and queues the result words it causes.
      function void note_request(csf_op_type op, logic [TID_W-1:0] tid,
                                 logic signed [VALUE_W-1:0] value);
         csf_status_type   st;
         logic [TID_W-1:0] t;
         case (op)
            OP_OPEN: begin
               count  = value;
               closed = 1'b0;
               rd_ptr = '0;
               wr_ptr = '0;
               queued = 0;
               queue_result(ST_OK, 1'b0, 1'b0, '0, 1'b1);
            end
            OP_WAIT: begin
               if (closed) begin
                  queue_result(ST_CLOSED, 1'b0, 1'b0, '0, 1'b1);
               end else if (count == COUNT_MIN) begin
                  queue_result(ST_FULL, 1'b0, 1'b0, '0, 1'b1);
               end else if (count <= 0) begin
                  // The count goes negative, so the caller has to be queued.
                  if (queued >= QUEUE_DEPTH) begin
                     queue_result(ST_FULL, 1'b0, 1'b0, '0, 1'b1);
                  end else begin
                     waiters[wr_ptr] = tid;
                     wr_ptr = (wr_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
                     queued++;
                     count = count - VALUE_W'(1);
                     queue_result(ST_OK, 1'b1, 1'b0, '0, 1'b1);
                  end
               end else begin
                  count = count - VALUE_W'(1);
                  queue_result(ST_OK, 1'b0, 1'b0, '0, 1'b1);
               end
            end
            OP_SIGNAL: begin
               st = ST_OK;
               if (count == COUNT_MAX) begin
                  st = ST_FULL;
               end else begin
                  count = count + VALUE_W'(1);
               end
               if (queued > 0) begin
                  t = take_waiter();
                  queue_result(st, 1'b0, 1'b1, t, 1'b1);
               end else begin
                  queue_result(st, 1'b0, 1'b0, '0, 1'b1);
               end
            end
            default: begin
               // Close releases every waiter in order and marks the final one.
               closed = 1'b1;
               if (queued == 0) begin
                  queue_result(ST_OK, 1'b0, 1'b0, '0, 1'b1);
               end else begin
                  while (queued > 0) begin
                     t = take_waiter();
                     queue_result(ST_OK, 1'b0, 1'b1, t, queued == 0);
                  end
               end
               rd_ptr = '0;
               wr_ptr = '0;
            end
         endcase
      endfunction

      // Compares one accepted result word with the oldest expected word.
      function void check_word(csf_rsp_type got);
         csf_rsp_type want;
         if (expected_words.size() == 0) begin
            failures++;
            if (failures <= 10) begin
               $display("unexpected result word: status %0d block %0b rel %0b/%0h last %0b",
                        got.status, got.must_block, got.rel_valid, got.rel_thread, got.last);
            end
            return;
         end
         want = expected_words.pop_front();
         if (want.status !== got.status || want.must_block !== got.must_block ||
             want.rel_valid !== got.rel_valid || want.rel_thread !== got.rel_thread ||
             want.last !== got.last) begin
            failures++;
            if (failures <= 10) begin
               $display("result mismatch: expected status %0d block %0b rel %0b/%0h last %0b",
                        want.status, want.must_block, want.rel_valid, want.rel_thread,
                        want.last);
               $display("                 actual   status %0d block %0b rel %0b/%0h last %0b",
                        got.status, got.must_block, got.rel_valid, got.rel_thread, got.last);
            end
         end
      endfunction

      function int pending();
         return expected_words.size();
      endfunction
   endclass

   logic                      clock = 1'b0;
   logic                      reset = 1'b1;
   logic                      req_push = 1'b0;
   logic                      req_full;
   logic [1:0]                req_kind = OP_OPEN;
   logic [TID_W-1:0]          req_thread_id = '0;
   logic signed [VALUE_W-1:0] req_open_value = '0;
   logic                      rsp_empty;
   logic                      rsp_pop = 1'b0;
   logic [1:0]                rsp_status;
   logic                      rsp_must_block;
   logic                      rsp_released_valid;
   logic [TID_W-1:0]          rsp_released_thread;
   logic                      rsp_last;

   semaphore_score score = new();
   csf_rsp_type    seen_word;
   int             words_sent = 0;
   int             burst_left = 0;
   int             pop_mode = POP_ALWAYS;
   int             mode_left = 0;
   int             stall_left = 0;

   counting_semaphore_fifo_waiters i_dut (
      .clock               (clock),
      .reset               (reset),
      .req_push            (req_push),
      .req_full            (req_full),
      .req_kind            (req_kind),
      .req_thread_id       (req_thread_id),
      .req_open_value      (req_open_value),
      .rsp_empty           (rsp_empty),
      .rsp_pop             (rsp_pop),
      .rsp_status          (rsp_status),
      .rsp_must_block      (rsp_must_block),
      .rsp_released_valid  (rsp_released_valid),
      .rsp_released_thread (rsp_released_thread),
      .rsp_last            (rsp_last)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // Sends one request word, waits for it to be taken, then idles between bursts.
   task automatic send_op(csf_op_type op, logic [TID_W-1:0] tid,
                          logic signed [VALUE_W-1:0] value);
      int gap;
      req_push       <= 1'b1;
      req_kind       <= op;
      req_thread_id  <= tid;
      req_open_value <= value;
      do @(posedge clock); while (req_full);
      score.note_request(op, tid, value);
      words_sent++;
      if (burst_left > 0) begin
         burst_left--;
      end else begin
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
         burst_left = ($urandom_range(0, 4) == 0) ? 30 : $urandom_range(0, 10);
         if (gap > 0) begin
            req_push <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
   endtask

   // Result side: check each accepted word, then choose the next pop value.
   always @(posedge clock) begin
      if (!reset && !rsp_empty && rsp_pop) begin
         seen_word.status     = csf_status_type'(rsp_status);
         seen_word.must_block = rsp_must_block;
         seen_word.rel_valid  = rsp_released_valid;
         seen_word.rel_thread = rsp_released_thread;
         seen_word.last       = rsp_last;
         score.check_word(seen_word);
      end
      if (mode_left == 0) begin
         pop_mode  = $urandom_range(POP_ALWAYS, POP_BURSTY);
         mode_left = $urandom_range(8, 64);
      end
      mode_left--;
      case (pop_mode)
         POP_ALWAYS: rsp_pop <= 1'b1;
         POP_RANDOM: rsp_pop <= ($urandom_range(0, 1) == 1);
         default: begin
            if (stall_left > 0) begin
               stall_left--;
               rsp_pop <= 1'b0;
            end else begin
               stall_left = $urandom_range(0, 20);
               rsp_pop <= 1'b1;
            end
         end
      endcase
   end

   // Main sequence: reset, directed cases, random scenarios, drain and verdict.
   initial begin
      int                        scenario;
      int                        n;
      int                        r;
      logic signed [VALUE_W-1:0] v;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // Directed part: extreme values and special cases of the semaphore.
      send_op(OP_WAIT, 8'hFF, '0);
      send_op(OP_SIGNAL, 8'h00, '0);
      send_op(OP_OPEN, 8'h00, COUNT_MAX);
      send_op(OP_SIGNAL, 8'h00, '0);
      send_op(OP_WAIT, 8'h00, '0);
      send_op(OP_OPEN, 8'hFF, COUNT_MIN);
      send_op(OP_WAIT, 8'h5A, '0);
      send_op(OP_SIGNAL, 8'hA5, '0);
      send_op(OP_OPEN, 8'h00, 16'sd0);
      send_op(OP_WAIT, 8'h11, '0);
      send_op(OP_WAIT, 8'h22, '0);
      send_op(OP_OPEN, 8'h00, 16'sd5);
      send_op(OP_CLOSE, 8'h00, '0);
      send_op(OP_CLOSE, 8'hFF, '1);
      send_op(OP_WAIT, 8'hA5, '0);
      send_op(OP_SIGNAL, 8'h00, '0);
      send_op(OP_OPEN, 8'h00, -16'sd1);
      send_op(OP_WAIT, 8'h33, '0);
      send_op(OP_WAIT, 8'h44, '0);
      send_op(OP_WAIT, 8'h55, '0);
      send_op(OP_CLOSE, 8'h00, '0);
      send_op(OP_WAIT, 8'h66, '0);

      // Random part; the first scenario always sends a run of waits that can fill the waiter queue past its depth.
      n = words_sent + RANDOM_WORDS;
      scenario = SC_FILL;
      while (words_sent < n) begin
         case (scenario)
            SC_MIXED: begin
               send_op(OP_OPEN, 8'($urandom), VALUE_W'($urandom_range(0, 6)) - 16'sd3);
               repeat ($urandom_range(4, 12)) begin
                  r = $urandom_range(0, 99);
                  if (r < 50) begin
                     send_op(OP_WAIT, 8'($urandom), VALUE_W'($urandom));
                  end else if (r < 85) begin
                     send_op(OP_SIGNAL, 8'($urandom), VALUE_W'($urandom));
                  end else if (r < 92) begin
                     send_op(OP_OPEN, 8'($urandom), VALUE_W'($urandom_range(0, 4)) - 16'sd2);
                  end else begin
                     send_op(OP_CLOSE, 8'($urandom), VALUE_W'($urandom));
                  end
               end
               if ($urandom_range(0, 2) == 0) begin
                  send_op(OP_CLOSE, 8'($urandom), VALUE_W'($urandom));
               end
            end
            SC_FILL: begin
               send_op(OP_OPEN, 8'($urandom), VALUE_W'($urandom_range(0, 2)) - 16'sd1);
               repeat ($urandom_range(15, 19)) begin
                  send_op(OP_WAIT, 8'($urandom), VALUE_W'($urandom));
               end
               if ($urandom_range(0, 1) == 0) begin
                  send_op(OP_CLOSE, 8'($urandom), VALUE_W'($urandom));
               end else begin
                  repeat ($urandom_range(3, 8)) begin
                     send_op(OP_SIGNAL, 8'($urandom), VALUE_W'($urandom));
                  end
               end
            end
            SC_EDGE: begin
               // Start next to one end of the count range and push against it.
               if ($urandom_range(0, 1) == 0) begin
                  v = COUNT_MAX - VALUE_W'($urandom_range(0, 2));
                  send_op(OP_OPEN, 8'($urandom), v);
                  repeat ($urandom_range(4, 8)) begin
                     send_op(($urandom_range(0, 3) == 0) ? OP_WAIT : OP_SIGNAL,
                             8'($urandom), VALUE_W'($urandom));
                  end
               end else begin
                  v = COUNT_MIN + VALUE_W'($urandom_range(0, 2));
                  send_op(OP_OPEN, 8'($urandom), v);
                  repeat ($urandom_range(4, 8)) begin
                     send_op(($urandom_range(0, 3) == 0) ? OP_SIGNAL : OP_WAIT,
                             8'($urandom), VALUE_W'($urandom));
                  end
               end
            end
            default: begin
               repeat ($urandom_range(3, 8)) begin
                  send_op(csf_op_type'($urandom_range(0, 3)), 8'($urandom),
                          VALUE_W'($urandom));
               end
            end
         endcase
         r = $urandom_range(0, 99);
         scenario = (r < 40) ? SC_MIXED : (r < 60) ? SC_FILL : (r < 80) ? SC_EDGE : SC_NOISE;
      end
      req_push <= 1'b0;

      // Drain all expected words, then allow time for stray ones.
      while (score.pending() != 0) @(posedge clock);
      repeat (40) @(posedge clock);
      if (score.failures == 0) begin
         $display("tb_top OK");
      end else begin
         $display("tb_top NOT OK");
      end
      $finish;
   end

   // Watchdog for a hung handshake.
   initial begin
      #6_000_000;
      $display("tb_top NOT OK");
      $finish;
   end

endmodule

@@ filelist.f @@
rtl/csf_pkg.sv
rtl/csf_ram.sv
rtl/csf_front.sv
rtl/csf_back.sv
rtl/counting_semaphore_fifo_waiters.sv
tb/sv/tb_top.sv
